// ===== rtl/centroid_proximity_grouping_assert.svh =====
// Assertion macros for the centroid proximity grouping RTL.
// Depends on nothing; included inside module bodies.
`ifndef CENTROID_PROXIMITY_GROUPING_ASSERT_SVH
`define CENTROID_PROXIMITY_GROUPING_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/cpg_pkg.sv =====
// Package for centroid proximity grouping: shared types and constants.
// Depends on nothing.
package cpg_pkg;
  localparam int unsigned MAX_CLUSTERS = 64;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned TH_W = 16;

  typedef struct packed {
    logic [IDX_W-1:0] group_id;
    logic [IDX_W-1:0] member_index;
    logic             group_start;
    logic             overflow;
    logic             last_result;
  } result_t;
endpackage

// ===== rtl/centroid_proximity_grouping.sv =====
// Channel | accepted when            | contents
// s_axis  | s_axis_tvalid&tready     | centroid x, y; tlast ends the set
// m_axis  | m_axis_tvalid&tready     | group id, member index; tuser start/overflow flags
// cfg     | cfg_we                   | merge threshold
// Loading accepts one centroid per cycle. Grouping scans the stored centroids from index 0 for
// each stack top: visited centroids are skipped, unvisited ones pass through the distance and
// compare states, and each result found is emitted before the next stack top is read back.
// Reset is synchronous; input is not taken while grouping. Output stalls hold the engine.
module centroid_proximity_grouping (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // centroid_x [15:0], centroid_y [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // group_id [5:0], member_index [11:6], zero fill
  output logic [1:0]  m_axis_tuser,  // group_start [0], overflow [1]
  output logic        m_axis_tlast
);
  import cpg_pkg::*;

  logic [TH_W-1:0] threshold;
  logic e_valid, e_ready, busy;
  result_t e_res, q_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd384;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  cpg_engine u_engine (
    .clk, .rst, .threshold,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_x(s_axis_tdata[COORD_BITS-1:0]), .in_y(s_axis_tdata[16+COORD_BITS-1:16]),
    .in_last(s_axis_tlast),
    .res_valid(e_valid), .res_ready(e_ready), .res(e_res), .busy);

  cpg_out_queue u_queue (
    .clk, .rst, .in_valid(e_valid), .in_ready(e_ready), .in_data(e_res),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(q_res));

  assign m_axis_tdata = {4'b0000, q_res.member_index, q_res.group_id};
  assign m_axis_tuser = {q_res.overflow, q_res.group_start};
  assign m_axis_tlast = q_res.last_result;

  `include "centroid_proximity_grouping_assert.svh"
  `CPG_ASSERT_IMP(a_no_load_busy, busy, !s_axis_tready)
  `CPG_ASSERT_IMP(a_out_needs_run, e_valid, busy)
endmodule

// ===== rtl/cpg_ram.sv =====
// Generic single write port RAM with registered read.
// Depends on nothing.
module cpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cpg_engine.sv =====
// Grouping engine: stores centroids and runs the depth first search.
// Depends on cpg_pkg and cpg_ram.
module cpg_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cpg_pkg::TH_W-1:0]        threshold,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cpg_pkg::COORD_BITS-1:0]  in_x,
  input  logic [cpg_pkg::COORD_BITS-1:0]  in_y,
  input  logic                            in_last,
  output logic                            res_valid,
  input  logic                            res_ready,
  output cpg_pkg::result_t                res,
  output logic                            busy
);
  import cpg_pkg::*;

  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int CW = $clog2(MAX_CLUSTERS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_CLUSTERS);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_TOPR = 3'd2;
  localparam logic [2:0] S_TOPW = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_DIST = 3'd5;
  localparam logic [2:0] S_CMP = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state;
  logic [CW-1:0] loaded;
  logic ovf;
  logic [AW-1:0] group_cnt;
  logic [CW-1:0] seed;
  logic [CW-1:0] scan;
  logic [CW-1:0] depth;
  logic [MAX_CLUSTERS-1:0] visited;
  logic [COORD_BITS-1:0] top_x, top_y;
  logic [AW-1:0] emit_idx;
  logic emit_start;
  logic [2*COORD_BITS+1:0] sq_x, sq_y;
  logic [2*TH_W-1:0] th_sq;
  logic [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0] ax, ay;
  logic [2*COORD_BITS+2:0] d2;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [COORD_BITS-1:0] rx, ry;
  logic stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr, stk_rdata;

  cpg_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_CLUSTERS)) u_x (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(in_x), .raddr(ram_raddr), .rdata(rx));
  cpg_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_CLUSTERS)) u_y (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(in_y), .raddr(ram_raddr), .rdata(ry));
  cpg_ram #(.WIDTH(AW), .DEPTH(MAX_CLUSTERS)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(emit_idx), .raddr(stk_raddr),
    .rdata(stk_rdata));

  assign in_ready = (state == S_LOAD);
  assign busy = (state != S_LOAD);
  assign ram_we = in_valid && in_ready && (loaded < MAXC);
  assign ram_waddr = loaded[AW-1:0];
  assign stk_raddr = AW'(depth - 1'b1);
  assign stk_waddr = depth[AW-1:0];
  assign stk_we = (state == S_EMIT) && res_ready;

  always_comb begin
    ram_raddr = scan[AW-1:0];
    if (state == S_TOPR || state == S_TOPW) begin
      ram_raddr = stk_rdata;
    end
  end

  assign dx = {rx[COORD_BITS-1], rx} - {top_x[COORD_BITS-1], top_x};
  assign dy = {ry[COORD_BITS-1], ry} - {top_y[COORD_BITS-1], top_y};
  assign ax = dx[COORD_BITS] ? -dx : dx;
  assign ay = dy[COORD_BITS] ? -dy : dy;
  assign d2 = {1'b0, sq_x} + {1'b0, sq_y};

  assign res_valid = (state == S_EMIT);
  assign res.group_id = group_cnt;
  assign res.member_index = emit_idx;
  assign res.group_start = emit_start;
  assign res.overflow = ovf;
  assign res.last_result = (loaded - 1'b1 == CW'($countones(visited)));

  always_ff @(posedge clk) begin
    th_sq <= threshold * threshold;
    if (state == S_DIST) begin
      sq_x <= (2*COORD_BITS+2)'(ax * ax);
      sq_y <= (2*COORD_BITS+2)'(ay * ay);
    end
    if (state == S_SCAN && scan == '0) begin
      top_x <= rx;
      top_y <= ry;
    end
    if (rst) begin
      state <= S_LOAD;
      loaded <= '0;
      ovf <= 1'b0;
      group_cnt <= '0;
      visited <= '0;
      depth <= '0;
      seed <= '0;
      scan <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (loaded < MAXC) begin
              loaded <= loaded + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (in_last) begin
              state <= S_SEED;
              seed <= '0;
            end
          end
        end
        S_SEED: begin
          if (seed >= loaded) begin
            state <= S_LOAD;
            loaded <= '0;
            ovf <= 1'b0;
            group_cnt <= '0;
            visited <= '0;
            depth <= '0;
          end else if (visited[seed[AW-1:0]]) begin
            seed <= seed + 1'b1;
          end else begin
            emit_idx <= seed[AW-1:0];
            emit_start <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_TOPR: state <= S_TOPW;
        S_TOPW: begin
          scan <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan >= loaded) begin
            depth <= depth - 1'b1;
            if (depth == CW'(1)) begin
              group_cnt <= group_cnt + 1'b1;
              seed <= seed + 1'b1;
              state <= S_SEED;
            end else begin
              state <= S_TOPR;
            end
          end else if (visited[scan[AW-1:0]]) begin
            scan <= scan + 1'b1;
          end else begin
            state <= S_DIST;
          end
        end
        S_DIST: state <= S_CMP;
        S_CMP: begin
          if ({1'b0, d2} <= {{(2*COORD_BITS+4-2*TH_W){1'b0}}, th_sq} &&
              depth < MAXC) begin
            emit_idx <= scan[AW-1:0];
            emit_start <= 1'b0;
            state <= S_EMIT;
          end else begin
            scan <= scan + 1'b1;
            state <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            visited[emit_idx] <= 1'b1;
            depth <= depth + 1'b1;
            state <= S_TOPR;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== rtl/cpg_out_queue.sv =====
// Two entry result queue that decouples the engine from the output stream.
// Depends on cpg_pkg.
module cpg_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cpg_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cpg_pkg::result_t out_data
);
  import cpg_pkg::*;

  result_t q [2];
  logic rd, wr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data = q[rd];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q[wr] <= in_data;
    end
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        wr <= ~wr;
      end
      if (out_valid && out_ready) begin
        rd <= ~rd;
      end
      count <= count + 2'((in_valid && in_ready) ? 1 : 0) - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end
endmodule
